### hw/rtl/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; include guard below
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication failed");

// next-cycle implication, held off during reset
`define ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle implication failed");

`endif

### hw/rtl/mrd_pkg.sv
// types and constants of the mqtt receive deframer
// no dependencies; used by the parser, the top level and the checker
`timescale 1ns / 1ps

package mrd_pkg;

   localparam int LenW = 28;

   // input item kinds
   localparam logic [1:0] KIND_RX_BYTE    = 2'd0;
   localparam logic [1:0] KIND_CONNECT    = 2'd1;
   localparam logic [1:0] KIND_DISCONNECT = 2'd2;

   // byte roles
   localparam logic [1:0] ROLE_HEADER = 2'd0;
   localparam logic [1:0] ROLE_LENGTH = 2'd1;
   localparam logic [1:0] ROLE_BODY   = 2'd2;
   localparam logic [1:0] ROLE_EVENT  = 2'd3;

   // link states
   localparam logic [1:0] LINK_DOWN = 2'd0;
   localparam logic [1:0] LINK_UP   = 2'd1;
   localparam logic [1:0] LINK_ERR  = 2'd2;

   localparam logic [3:0] TYPE_CONNACK = 4'd2;
   localparam logic [7:0] CONT_BIT     = 8'h80;
   localparam logic [7:0] GROUP_MASK   = 8'h7F;
   localparam logic [7:0] NIBBLE_MASK  = 8'h0F;

   typedef struct packed {
      logic [1:0]      byte_role;
      logic [3:0]      ctrl_type;
      logic [LenW-1:0] remaining_length;
      logic            packet_end;
      logic            length_error;
      logic            connected;
      logic [1:0]      link_state;
      logic [7:0]      connack_code;
   } rsp_type;

endpackage

### hw/rtl/mqtt_rx_packet_deframer.sv
// mqtt receive deframer: splits a received byte stream into control packets
// Usage:
//  - req channel: one item per received byte (req_kind 0, req_rx_byte) or a
//    local connect (kind 1) / disconnect (kind 2) event. kind 3 is reported
//    as a local event and changes nothing.
//  - rsp channel: exactly one result item per request item, in order: the
//    byte role, packet type, remaining length decoded so far, packet end and
//    length error marks, and the link state after the item.
//  - an accepted item is held in the input register; its result is loaded
//    into the output register once that register is free, and rsp_valid
//    rises with that load.
//  - throughput is one item per cycle while rsp_ready stays high, set by the
//    single parse state update between the two registers.
//  - if the receiver stalls, the result holds in the output register and one
//    more item waits in the input register; req_ready then drops until
//    rsp_ready returns.
//  - reset (synchronous, active high) empties both registers and returns
//    the parser to expect a header byte with the link disconnected.
//  - depends on mrd_pkg and mrd_parse
`timescale 1ns / 1ps

module mqtt_rx_packet_deframer (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_kind,
   input  logic [7:0]                req_rx_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_byte_role,
   output logic [3:0]                rsp_ctrl_type,
   output logic [mrd_pkg::LenW-1:0]  rsp_remaining_length,
   output logic                      rsp_packet_end,
   output logic                      rsp_length_error,
   output logic                      rsp_connected,
   output logic [1:0]                rsp_link_state,
   output logic [7:0]                rsp_connack_code
);
   import mrd_pkg::*;

   logic       in_valid_ff;
   logic [1:0] kind_ff;
   logic [7:0] byte_ff;
   logic       out_valid_ff;
   rsp_type    rsp_ff;
   rsp_type    rsp_in;
   logic       advance;

   // move the held item into the result register when that one is free
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   mrd_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .kind    (kind_ff),
      .rx_byte (byte_ff),
      .rsp     (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) in_valid_ff <= req_valid;
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         kind_ff <= req_kind;
         byte_ff <= req_rx_byte;
      end
      if (advance) rsp_ff <= rsp_in;
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_byte_role        = rsp_ff.byte_role;
   assign rsp_ctrl_type        = rsp_ff.ctrl_type;
   assign rsp_remaining_length = rsp_ff.remaining_length;
   assign rsp_packet_end       = rsp_ff.packet_end;
   assign rsp_length_error     = rsp_ff.length_error;
   assign rsp_connected        = rsp_ff.connected;
   assign rsp_link_state       = rsp_ff.link_state;
   assign rsp_connack_code     = rsp_ff.connack_code;

endmodule

### hw/rtl/mrd_parse.sv
// packet parse state and per-item result logic of the mqtt receive deframer
// depends on mrd_pkg
`timescale 1ns / 1ps

module mrd_parse (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [1:0]       kind,
   input  logic [7:0]       rx_byte,
   output mrd_pkg::rsp_type rsp
);
   import mrd_pkg::*;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_LENGTH = 2'd1,
      PH_BODY   = 2'd2
   } phase_type;

   phase_type       phase_ff, phase_in;
   logic [3:0]      type_ff, type_in;
   logic [LenW-1:0] accum_ff, accum_in;
   logic [2:0]      count_ff, count_in;
   logic [LenW-1:0] left_ff, left_in;
   logic [1:0]      index_ff, index_in;
   logic            conn_ff, conn_in;
   logic [1:0]      link_ff, link_in;
   logic [7:0]      code_ff, code_in;

   logic [6:0]      group;
   logic            more;
   logic [LenW-1:0] shifted;
   logic [LenW-1:0] sum;
   logic [LenW-1:0] left_dec;

   assign group    = 7'(rx_byte & GROUP_MASK);
   assign more     = (rx_byte & CONT_BIT) != 8'd0;
   assign sum      = accum_ff + shifted;
   assign left_dec = left_ff - LenW'(1);

   // least significant group first
   always_comb begin
      case (count_ff[1:0])
         2'd0:    shifted = {21'd0, group};
         2'd1:    shifted = {14'd0, group, 7'd0};
         2'd2:    shifted = {7'd0, group, 14'd0};
         default: shifted = {group, 21'd0};
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      type_in  = type_ff;
      accum_in = accum_ff;
      count_in = count_ff;
      left_in  = left_ff;
      index_in = index_ff;
      conn_in  = conn_ff;
      link_in  = link_ff;
      code_in  = code_ff;

      rsp.byte_role        = ROLE_EVENT;
      rsp.remaining_length = accum_ff;
      rsp.packet_end       = 1'b0;
      rsp.length_error     = 1'b0;

      if (kind == KIND_CONNECT) begin
         conn_in = 1'b1;
         link_in = LINK_UP;
      end else if (kind == KIND_DISCONNECT) begin
         conn_in = 1'b0;
         link_in = LINK_DOWN;
      end else if (kind == KIND_RX_BYTE) begin
         case (phase_ff)
            PH_LENGTH: begin
               rsp.byte_role        = ROLE_LENGTH;
               accum_in             = sum;
               count_in             = {1'b0, count_ff[1:0]} + 3'd1;
               rsp.remaining_length = sum;
               // fourth group ends the length even if it continues
               if (!more || count_ff[1:0] == 2'd3) begin
                  rsp.length_error = more;
                  if (sum == '0) begin
                     rsp.packet_end = 1'b1;
                     phase_in       = PH_HEADER;
                  end else begin
                     left_in  = sum;
                     index_in = 2'd0;
                     phase_in = PH_BODY;
                  end
               end
            end
            PH_BODY: begin
               rsp.byte_role = ROLE_BODY;
               // connack return code is the second body byte
               if (type_ff == TYPE_CONNACK && index_ff == 2'd1 && accum_ff >= LenW'(2)) begin
                  code_in = rx_byte;
                  if (rx_byte == 8'd0) begin
                     conn_in = 1'b1;
                     link_in = LINK_UP;
                  end else begin
                     conn_in = 1'b0;
                     link_in = LINK_ERR;
                  end
               end
               if (index_ff != 2'd3) index_in = index_ff + 2'd1;
               left_in = left_dec;
               if (left_dec == '0) begin
                  rsp.packet_end = 1'b1;
                  phase_in       = PH_HEADER;
               end
            end
            default: begin
               rsp.byte_role        = ROLE_HEADER;
               type_in              = 4'((rx_byte >> 4) & NIBBLE_MASK);
               accum_in             = '0;
               count_in             = 3'd0;
               left_in              = '0;
               index_in             = 2'd0;
               phase_in             = PH_LENGTH;
               rsp.remaining_length = '0;
            end
         endcase
      end

      rsp.ctrl_type    = type_in;
      rsp.connected    = conn_in;
      rsp.link_state   = link_in;
      rsp.connack_code = code_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         type_ff  <= 4'd0;
         accum_ff <= '0;
         count_ff <= 3'd0;
         left_ff  <= '0;
         index_ff <= 2'd0;
         conn_ff  <= 1'b0;
         link_ff  <= LINK_DOWN;
         code_ff  <= 8'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         type_ff  <= type_in;
         accum_ff <= accum_in;
         count_ff <= count_in;
         left_ff  <= left_in;
         index_ff <= index_in;
         conn_ff  <= conn_in;
         link_ff  <= link_in;
         code_ff  <= code_in;
      end
   end

endmodule

### hw/rtl/mrd_checker.sv
// port-level checks for the mqtt receive deframer, bound to the top level
// depends on mrd_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mrd_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [1:0]               rsp_byte_role,
   input logic [mrd_pkg::LenW-1:0] rsp_remaining_length,
   input logic                     rsp_packet_end,
   input logic                     rsp_length_error,
   input logic                     rsp_connected,
   input logic [1:0]               rsp_link_state
);
   import mrd_pkg::*;

   logic end_ok;

   assign end_ok  = rsp_byte_role == ROLE_LENGTH || rsp_byte_role == ROLE_BODY;

   // a stalled result stays put
   `ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_byte_role) && $stable(rsp_remaining_length))

   // only length or body bytes can close a packet
   `ASSERT_IMP(a_end_role, clock, reset, rsp_valid && rsp_packet_end, end_ok)

   // overlong length is flagged only on a length byte
   `ASSERT_IMP(a_lerr_role, clock, reset, rsp_valid && rsp_length_error,
      rsp_byte_role == ROLE_LENGTH)

   // header bytes restart the length
   `ASSERT_IMP(a_hdr_len, clock, reset, rsp_valid && rsp_byte_role == ROLE_HEADER,
      rsp_remaining_length == '0)

   // connected flag tracks the link state
   `ASSERT_IMP(a_conn_link, clock, reset, rsp_valid,
      rsp_connected == (rsp_link_state == LINK_UP))

endmodule

bind mqtt_rx_packet_deframer mrd_checker u_mrd_checker (.*);
